### design/gg_pkg.sv
// gg_pkg: shared types, codes and constants for the gillespie step block
// no dependencies; used by gg_mul, gg_div and the step module
`timescale 1ns / 1ps
`default_nettype none

package gg_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASAL_K = 3'd0,
    CFG_MAX_K   = 3'd1,
    CFG_BASAL_M = 3'd2,
    CFG_MAX_M   = 3'd3,
    CFG_K_HALF  = 3'd4,
    CFG_M_HALF  = 3'd5,
    CFG_BINDING = 3'd6
  } cfg_reg_e;

  localparam logic [47:0] BASAL_K_RST = 48'd87960930;
  localparam logic [47:0] MAX_K_RST   = 48'd208907209277;
  localparam logic [47:0] BASAL_M_RST = 48'd2089072093;
  localparam logic [47:0] MAX_M_RST   = 48'd68719476736;
  localparam logic [19:0] K_HALF_RST  = 20'd5000;
  localparam logic [19:0] M_HALF_RST  = 20'd2500;
  localparam logic [47:0] BINDING_RST = 48'd43980;

  // rate constants in UQ.40
  localparam logic [63:0] RATE_TRANSLATE  = 64'd219902325555;
  localparam logic [63:0] RATE_MRNA_DECAY = 64'd5497558139;
  localparam logic [63:0] RATE_PROT_DECAY = 64'd109951163;
  localparam logic [63:0] LN2_Q40         = 64'd762123384786;

  localparam logic [6:0] HILL_QBITS = 7'd41;
  localparam logic [6:0] TAU_QBITS  = 7'd61;
  localparam logic [3:0] LAST_REACTION = 4'd8;
  localparam logic [4:0] LOG_STEPS_M1  = 5'd31;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_KK,
    S_MUL_HH,
    S_DIV_HILL,
    S_MUL_HILL,
    S_MUL_MK,
    S_MUL_RATE,
    S_NORM,
    S_LOG_SQ,
    S_LN_MUL,
    S_DIV_TAU,
    S_MUL_TGT,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [64:0] rem_init;
    logic [63:0] dend;
    logic [6:0]  nbits;
    logic [64:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] sat_low64(input logic [127:0] p);
    return (p[127:64] != 64'd0) ? '1 : p[63:0];
  endfunction

endpackage

`default_nettype wire

### design/gg_if.sv
// gg_in_if / gg_out_if: valid-ready channels of the gillespie step block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface gg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] rand_time;
  logic [31:0] rand_pick;
  modport source (output valid, rand_time, rand_pick, input ready);
  modport sink (input valid, rand_time, rand_pick, output ready);
endinterface

interface gg_out_if #(
  parameter int PROTEIN_WIDTH = 20,
  parameter int MRNA_WIDTH    = 16,
  parameter int TIME_WIDTH    = 48
);
  logic                     valid;
  logic                     ready;
  logic                     step_taken;
  logic [3:0]               reaction;
  logic [TIME_WIDTH-1:0]    event_time;
  logic [PROTEIN_WIDTH-1:0] k_count;
  logic [PROTEIN_WIDTH-1:0] m_count;
  logic [MRNA_WIDTH-1:0]    k_mrna_count;
  logic [MRNA_WIDTH-1:0]    m_mrna_count;
  modport source (output valid, step_taken, reaction, event_time, k_count, m_count,
                  k_mrna_count, m_mrna_count, input ready);
  modport sink (input valid, step_taken, reaction, event_time, k_count, m_count,
                k_mrna_count, m_mrna_count, output ready);
endinterface

`default_nettype wire

### design/gg_mul.sv
// gg_mul: 64x64 multiplier built from one 32x32 multiplier, summing up to four partial products
// depends on gg_pkg
`timescale 1ns / 1ps
`default_nettype none

module gg_mul (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gg_pkg::mul_req_t req,
  output gg_pkg::mul_rsp_t      rsp
);

  logic [63:0]  a_r, b_r;
  logic [127:0] acc;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic         pp_valid;
  logic [2:0]   idx;
  logic [2:0]   nparts;
  logic         busy;
  logic         done;
  logic [31:0]  op_a, op_b;
  logic [1:0]   op_sh;

  always_comb begin
    unique case (idx[1:0])
      2'd0: begin op_a = a_r[31:0];  op_b = b_r[31:0];  op_sh = 2'd0; end
      2'd1: begin op_a = a_r[31:0];  op_b = b_r[63:32]; op_sh = 2'd1; end
      2'd2: begin op_a = a_r[63:32]; op_b = b_r[31:0];  op_sh = 2'd1; end
      default: begin op_a = a_r[63:32]; op_b = b_r[63:32]; op_sh = 2'd2; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      pp_valid <= 1'b0;
      idx      <= 3'd0;
      nparts   <= 3'd4;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a_r      <= req.a;
        b_r      <= req.b;
        acc      <= '0;
        idx      <= 3'd0;
        pp_valid <= 1'b0;
        busy     <= 1'b1;
        // both upper halves zero: a single partial product does it
        nparts   <= (req.a[63:32] == 32'd0 && req.b[63:32] == 32'd0) ? 3'd1 : 3'd4;
      end else if (busy) begin
        if (pp_valid) begin
          acc <= acc + ({64'd0, pp} << (7'd32 * {5'd0, pp_sh}));
        end
        if (idx < nparts) begin
          pp       <= {32'd0, op_a} * {32'd0, op_b};
          pp_sh    <= op_sh;
          pp_valid <= 1'b1;
          idx      <= idx + 3'd1;
        end else begin
          pp_valid <= 1'b0;
          busy     <= 1'b0;
          done     <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

`default_nettype wire

### design/gg_div.sv
// gg_div: restoring divider, one quotient bit per cycle
// depends on gg_pkg
`timescale 1ns / 1ps
`default_nettype none

module gg_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gg_pkg::div_req_t req,
  output gg_pkg::div_rsp_t      rsp
);

  logic [64:0] rem;
  logic [63:0] dend;
  logic [64:0] den;
  logic [63:0] quo;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [65:0] rem2;
  logic [65:0] diff;
  logic        ge;

  always_comb begin
    rem2 = {rem, dend[63]};
    diff = rem2 - {1'b0, den};
    ge   = rem2 >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= req.rem_init;
        dend <= req.dend;
        den  <= req.den;
        cnt  <= req.nbits;
        quo  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? diff[64:0] : rem2[64:0];
        quo  <= {quo[62:0], ge};
        dend <= {dend[62:0], 1'b0};
        cnt  <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

`default_nettype wire

### design/gillespie_gene_circuit_step.sv
// Gillespie direct-method step for a two-gene feedback circuit. Each input transfer carries
// two 32-bit uniform fractions and yields one result: the reaction fired, the new simulated
// time (UQ32.16) and the four molecule counts. The input is not ready while an item is
// in work; the work runs on one shared 32x32 multiplier (three Hill squares, the m*k
// product, nine propensity products, 32 squarings of the log, the ln2 scale and the pick
// target) and one bit-per-cycle divider (up to two 41-bit Hill quotients, one 61-bit time
// quotient). An input with a zero fraction is answered with step_taken low and the state
// unchanged; a state where all propensities are zero gives the same answer after the
// propensity pass. The next input can be taken while a result still waits in the output
// register.
// depends on gg_pkg, gg_if, gg_mul, gg_div
`timescale 1ns / 1ps
`default_nettype none

module gillespie_gene_circuit_step #(
  parameter int PROTEIN_WIDTH = 20,
  parameter int MRNA_WIDTH    = 16,
  parameter int TIME_WIDTH    = 48
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [gg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gg_pkg::CFG_DATA_W-1:0]   cfg_data,
  gg_in_if.sink                                in_ch,
  gg_out_if.source                             out_ch
);

  localparam logic [64:0] TMAX = (65'd1 << TIME_WIDTH) - 65'd1;
  localparam logic [PROTEIN_WIDTH-1:0] K_RST = PROTEIN_WIDTH'(500);
  localparam logic [PROTEIN_WIDTH-1:0] M_RST = PROTEIN_WIDTH'(150);

  gg_pkg::state_t state, state_next;

  logic [47:0] basal_k_rate, max_k_rate, basal_m_rate, max_m_rate, binding_rate;
  logic [19:0] k_half, m_half;

  logic [TIME_WIDTH-1:0]    clock_now;
  logic [PROTEIN_WIDTH-1:0] k_level, m_level;
  logic [MRNA_WIDTH-1:0]    k_mrna_level, m_mrna_level;

  logic [31:0] rand_time, rand_pick;
  logic        launched;
  logic        hidx;
  logic [3:0]  ridx;
  logic [3:0]  sidx;
  logic [63:0] kk, mk, fval, a0, lnv, tau, target;
  logic [64:0] den;
  logic [63:0] cum [9];
  logic [31:0] mant;
  logic [4:0]  expo;
  logic [4:0]  sq_cnt;
  logic [31:0] frac;
  logic [3:0]  pick;
  logic        taken;

  gg_pkg::mul_req_t mul_req;
  gg_pkg::mul_rsp_t mul_rsp;
  gg_pkg::div_req_t div_req;
  gg_pkg::div_rsp_t div_rsp;

  gg_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  gg_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  logic        in_xfer, out_free, rand_zero, op_mul, op_div;
  logic [64:0] den_sum;
  logic [63:0] hill_val, aval, a0_next;
  logic [32:0] sq;
  logic [37:0] lval;
  logic        hit;
  logic [64:0] tsum;
  logic [TIME_WIDTH-1:0]    clock_next;
  logic [PROTEIN_WIDTH-1:0] k_next, m_next;
  logic [MRNA_WIDTH-1:0]    kr_next, mr_next;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_ch.valid || out_ch.ready;
  assign rand_zero = (rand_time == 32'd0) || (rand_pick == 32'd0);
  assign op_mul    = (state == gg_pkg::S_MUL_KK) || (state == gg_pkg::S_MUL_HH) ||
                     (state == gg_pkg::S_MUL_HILL) || (state == gg_pkg::S_MUL_MK) ||
                     (state == gg_pkg::S_MUL_RATE) || (state == gg_pkg::S_LOG_SQ) ||
                     (state == gg_pkg::S_LN_MUL) || (state == gg_pkg::S_MUL_TGT);
  assign op_div    = (state == gg_pkg::S_DIV_HILL) || (state == gg_pkg::S_DIV_TAU);

  always_comb begin
    den_sum  = {1'b0, kk} + {1'b0, mul_rsp.prod[63:0]};
    // max*f is below 2^88, so the shifted value never saturates
    hill_val = gg_pkg::sat_add64(hidx ? {16'd0, basal_m_rate} : {16'd0, basal_k_rate},
                                 mul_rsp.prod[103:40]);
    aval     = (state == gg_pkg::S_MUL_HILL) ? hill_val : gg_pkg::sat_low64(mul_rsp.prod);
    a0_next  = gg_pkg::sat_add64(a0, aval);
    sq       = mul_rsp.prod[63:31];
    lval     = {6'd32 - {1'b0, expo}, 32'd0} - {6'd0, frac};
    hit      = target < cum[sidx];
    tsum     = 65'(clock_now) + {1'b0, tau};
    clock_next = (tsum > TMAX) ? '1 : tsum[TIME_WIDTH-1:0];
  end

  // saturating count updates for the picked reaction
  always_comb begin
    k_next  = k_level;
    m_next  = m_level;
    kr_next = k_mrna_level;
    mr_next = m_mrna_level;
    unique case (pick)
      4'd0: if (k_mrna_level != '1) kr_next = k_mrna_level + 1'b1;
      4'd1: if (m_mrna_level != '1) mr_next = m_mrna_level + 1'b1;
      4'd2: if (k_level != '1) k_next = k_level + 1'b1;
      4'd3: if (m_level != '1) m_next = m_level + 1'b1;
      4'd5: if (k_mrna_level != '0) kr_next = k_mrna_level - 1'b1;
      4'd6: if (m_mrna_level != '0) mr_next = m_mrna_level - 1'b1;
      4'd7: if (m_level != '0) m_next = m_level - 1'b1;
      default: if (k_level != '0) k_next = k_level - 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gg_pkg::S_IDLE:     if (in_xfer) state_next = gg_pkg::S_CHECK;
      gg_pkg::S_CHECK:    state_next = rand_zero ? gg_pkg::S_FINISH : gg_pkg::S_MUL_KK;
      gg_pkg::S_MUL_KK:   if (mul_rsp.done) state_next = gg_pkg::S_MUL_HH;
      gg_pkg::S_MUL_HH:
        if (mul_rsp.done) state_next = (den_sum == 65'd0) ? gg_pkg::S_MUL_HILL
                                                          : gg_pkg::S_DIV_HILL;
      gg_pkg::S_DIV_HILL: if (div_rsp.done) state_next = gg_pkg::S_MUL_HILL;
      gg_pkg::S_MUL_HILL:
        if (mul_rsp.done) state_next = hidx ? gg_pkg::S_MUL_MK : gg_pkg::S_MUL_HH;
      gg_pkg::S_MUL_MK:   if (mul_rsp.done) state_next = gg_pkg::S_MUL_RATE;
      gg_pkg::S_MUL_RATE:
        if (mul_rsp.done && ridx == gg_pkg::LAST_REACTION)
          state_next = (a0_next == 64'd0) ? gg_pkg::S_FINISH : gg_pkg::S_NORM;
      gg_pkg::S_NORM:     if (mant[31]) state_next = gg_pkg::S_LOG_SQ;
      gg_pkg::S_LOG_SQ:
        if (mul_rsp.done && sq_cnt == gg_pkg::LOG_STEPS_M1) state_next = gg_pkg::S_LN_MUL;
      gg_pkg::S_LN_MUL:   if (mul_rsp.done) state_next = gg_pkg::S_DIV_TAU;
      gg_pkg::S_DIV_TAU:  if (div_rsp.done) state_next = gg_pkg::S_MUL_TGT;
      gg_pkg::S_MUL_TGT:  if (mul_rsp.done) state_next = gg_pkg::S_SCAN;
      gg_pkg::S_SCAN:
        if (hit || sidx == gg_pkg::LAST_REACTION) state_next = gg_pkg::S_FINISH;
      gg_pkg::S_FINISH:   if (out_free) state_next = gg_pkg::S_IDLE;
      default:            state_next = gg_pkg::S_IDLE;
    endcase
  end

  // unit requests and handshake outputs
  always_comb begin
    in_ch.ready   = (state == gg_pkg::S_IDLE) && !rst;
    mul_req.start = op_mul && !launched;
    mul_req.a     = '0;
    mul_req.b     = '0;
    unique case (state)
      gg_pkg::S_MUL_KK: begin mul_req.a = 64'(k_level); mul_req.b = 64'(k_level); end
      gg_pkg::S_MUL_HH: begin
        mul_req.a = hidx ? 64'(m_half) : 64'(k_half);
        mul_req.b = mul_req.a;
      end
      gg_pkg::S_MUL_HILL: begin
        mul_req.a = hidx ? 64'(max_m_rate) : 64'(max_k_rate);
        mul_req.b = fval;
      end
      gg_pkg::S_MUL_MK: begin mul_req.a = 64'(m_level); mul_req.b = 64'(k_level); end
      gg_pkg::S_MUL_RATE: begin
        unique case (ridx)
          4'd2: begin mul_req.a = gg_pkg::RATE_TRANSLATE;  mul_req.b = 64'(k_mrna_level); end
          4'd3: begin mul_req.a = gg_pkg::RATE_TRANSLATE;  mul_req.b = 64'(m_mrna_level); end
          4'd4: begin mul_req.a = 64'(binding_rate);       mul_req.b = mk; end
          4'd5: begin mul_req.a = gg_pkg::RATE_MRNA_DECAY; mul_req.b = 64'(k_mrna_level); end
          4'd6: begin mul_req.a = gg_pkg::RATE_MRNA_DECAY; mul_req.b = 64'(m_mrna_level); end
          4'd7: begin mul_req.a = gg_pkg::RATE_PROT_DECAY; mul_req.b = 64'(m_level); end
          default: begin mul_req.a = gg_pkg::RATE_PROT_DECAY; mul_req.b = 64'(k_level); end
        endcase
      end
      gg_pkg::S_LOG_SQ:  begin mul_req.a = 64'(mant); mul_req.b = 64'(mant); end
      gg_pkg::S_LN_MUL:  begin mul_req.a = 64'(lval); mul_req.b = gg_pkg::LN2_Q40; end
      gg_pkg::S_MUL_TGT: begin mul_req.a = a0; mul_req.b = 64'(rand_pick); end
      default: ;
    endcase

    div_req.start = op_div && !launched;
    if (state == gg_pkg::S_DIV_TAU) begin
      // ln is below 2^45; quotient of (ln << 16) / a0 has at most 61 bits
      div_req.rem_init = '0;
      div_req.dend     = {lnv[44:0], 19'd0};
      div_req.nbits    = gg_pkg::TAU_QBITS;
      div_req.den      = {1'b0, a0};
    end else begin
      div_req.rem_init = {2'b0, kk[63:1]};
      div_req.dend     = {kk[0], 63'd0};
      div_req.nbits    = gg_pkg::HILL_QBITS;
      div_req.den      = den;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gg_pkg::S_IDLE;
      launched     <= 1'b0;
      out_ch.valid <= 1'b0;
      basal_k_rate <= gg_pkg::BASAL_K_RST;
      max_k_rate   <= gg_pkg::MAX_K_RST;
      basal_m_rate <= gg_pkg::BASAL_M_RST;
      max_m_rate   <= gg_pkg::MAX_M_RST;
      k_half       <= gg_pkg::K_HALF_RST;
      m_half       <= gg_pkg::M_HALF_RST;
      binding_rate <= gg_pkg::BINDING_RST;
      clock_now    <= '0;
      k_level      <= K_RST;
      m_level      <= M_RST;
      k_mrna_level <= '0;
      m_mrna_level <= '0;
      taken        <= 1'b0;
      hidx         <= 1'b0;
      ridx         <= 4'd2;
      sidx         <= 4'd0;
      sq_cnt       <= 5'd0;
    end else begin
      state <= state_next;
      if (mul_req.start || div_req.start) launched <= 1'b1;
      else if (mul_rsp.done || div_rsp.done) launched <= 1'b0;
      if (state == gg_pkg::S_FINISH && out_free) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          gg_pkg::CFG_BASAL_K: basal_k_rate <= cfg_data;
          gg_pkg::CFG_MAX_K:   max_k_rate   <= cfg_data;
          gg_pkg::CFG_BASAL_M: basal_m_rate <= cfg_data;
          gg_pkg::CFG_MAX_M:   max_m_rate   <= cfg_data;
          gg_pkg::CFG_K_HALF:  k_half       <= cfg_data[19:0];
          gg_pkg::CFG_M_HALF:  m_half       <= cfg_data[19:0];
          gg_pkg::CFG_BINDING: binding_rate <= cfg_data;
          default: ;
        endcase
      end

      if (in_xfer) begin
        rand_time <= in_ch.rand_time;
        rand_pick <= in_ch.rand_pick;
      end

      unique case (state)
        gg_pkg::S_CHECK: begin
          taken  <= 1'b0;
          hidx   <= 1'b0;
          ridx   <= 4'd2;
          sidx   <= 4'd0;
          sq_cnt <= 5'd0;
          a0     <= '0;
          frac   <= '0;
          pick   <= gg_pkg::LAST_REACTION;
          mant   <= rand_time;
          expo   <= 5'd31;
        end
        gg_pkg::S_MUL_KK: if (mul_rsp.done) kk <= mul_rsp.prod[63:0];
        gg_pkg::S_MUL_HH: if (mul_rsp.done) begin
          den  <= den_sum;
          fval <= '0;
        end
        gg_pkg::S_DIV_HILL: if (div_rsp.done) fval <= div_rsp.quo;
        gg_pkg::S_MUL_HILL: if (mul_rsp.done) begin
          a0             <= a0_next;
          cum[{3'd0, hidx}] <= a0_next;
          hidx           <= 1'b1;
        end
        gg_pkg::S_MUL_MK: if (mul_rsp.done) mk <= mul_rsp.prod[63:0];
        gg_pkg::S_MUL_RATE: if (mul_rsp.done) begin
          a0        <= a0_next;
          cum[ridx] <= a0_next;
          ridx      <= ridx + 4'd1;
          if (ridx == gg_pkg::LAST_REACTION) taken <= (a0_next != 64'd0);
        end
        gg_pkg::S_NORM: if (!mant[31]) begin
          mant <= {mant[30:0], 1'b0};
          expo <= expo - 5'd1;
        end
        gg_pkg::S_LOG_SQ: if (mul_rsp.done) begin
          mant   <= sq[32] ? sq[32:1] : sq[31:0];
          frac   <= {frac[30:0], sq[32]};
          sq_cnt <= sq_cnt + 5'd1;
        end
        gg_pkg::S_LN_MUL:  if (mul_rsp.done) lnv <= mul_rsp.prod[95:32];
        gg_pkg::S_DIV_TAU: if (div_rsp.done) tau <= div_rsp.quo;
        gg_pkg::S_MUL_TGT: if (mul_rsp.done) target <= mul_rsp.prod[95:32];
        gg_pkg::S_SCAN: begin
          if (hit) pick <= sidx;
          sidx <= sidx + 4'd1;
        end
        gg_pkg::S_FINISH: if (out_free) begin
          out_ch.step_taken <= taken;
          if (taken) begin
            clock_now    <= clock_next;
            k_level      <= k_next;
            m_level      <= m_next;
            k_mrna_level <= kr_next;
            m_mrna_level <= mr_next;
            out_ch.reaction     <= pick;
            out_ch.event_time   <= clock_next;
            out_ch.k_count      <= k_next;
            out_ch.m_count      <= m_next;
            out_ch.k_mrna_count <= kr_next;
            out_ch.m_mrna_count <= mr_next;
          end else begin
            out_ch.reaction     <= 4'd0;
            out_ch.event_time   <= clock_now;
            out_ch.k_count      <= k_level;
            out_ch.m_count      <= m_level;
            out_ch.k_mrna_count <= k_mrna_level;
            out_ch.m_mrna_count <= m_mrna_level;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/gg_chk.sv
// gg_chk: port-level assertions for the gillespie step block, bound to the top level
// depends on gillespie_gene_circuit_step
`timescale 1ns / 1ps
`default_nettype none

module gg_chk #(
  parameter int TIME_WIDTH = 48
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  step_taken,
  input wire logic [3:0]            reaction,
  input wire logic [TIME_WIDTH-1:0] event_time
);

  // one item at a time: the input closes right after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after a transfer");

  // reaction code in range, and zero for an ignored input
  a_reaction_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (reaction <= 4'd8) && (step_taken || reaction == 4'd0))
    else $error("bad reaction code on result");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(step_taken) && $stable(reaction) &&
                                $stable(event_time))
    else $error("result changed while stalled");

endmodule

bind gillespie_gene_circuit_step gg_chk #(.TIME_WIDTH(TIME_WIDTH)) u_gg_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .step_taken (out_ch.step_taken),
  .reaction   (out_ch.reaction),
  .event_time (out_ch.event_time)
);

`default_nettype wire

### sim/gillespie_gene_circuit_step_tb.sv
// gillespie_gene_circuit_step_tb: self-checking bench for the gillespie step block
// drives fixed and random fractions through the valid-ready channels, checks every result
// against a bit-exact predictor or a typed row's own; depends on gg_pkg, gg_if and the block
`timescale 1ns / 1ps

module gillespie_gene_circuit_step_tb;

  localparam logic [63:0] ONES64 = '1;
  localparam logic [47:0] RATE_MAX = '1;
  localparam logic [19:0] HALF_MAX = '1;

  typedef struct {
    bit        step_taken;
    bit [3:0]  reaction;
    bit [47:0] event_time;
    bit [19:0] k_count;
    bit [19:0] m_count;
    bit [15:0] k_mrna_count;
    bit [15:0] m_mrna_count;
  } gg_result_t;

  typedef struct {
    bit [31:0]  rand_time;
    bit [31:0]  rand_pick;
    bit         typed;
    gg_result_t result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [gg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  gg_in_if in_ch ();
  gg_out_if #(.PROTEIN_WIDTH(20), .MRNA_WIDTH(16), .TIME_WIDTH(48)) out_ch ();

  gillespie_gene_circuit_step dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  // predictor copy of the circuit
  logic [63:0] basal_k, max_k, basal_m, max_m, k_half, m_half, binding;
  logic [63:0] sim_clock, k_lvl, m_lvl, km_lvl, mm_lvl;

  gg_result_t results_due[$];
  int errors = 0;
  int results_seen = 0;
  int events_seen = 0;
  bit [8:0] reactions_hit = '0;
  int gap_pct = 0;
  int stall_pct = 0;

  function automatic logic [63:0] add_clip(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ONES64 : s[63:0];
  endfunction

  function automatic logic [63:0] mul_shift_clip(input logic [63:0] a, input logic [63:0] b,
                                                 input int sh);
    logic [127:0] p;
    logic [127:0] q;
    p = {64'd0, a} * {64'd0, b};
    q = p >> sh;
    return (q[127:64] != 0) ? ONES64 : q[63:0];
  endfunction

  function automatic logic [63:0] hill_q40(input logic [63:0] x, input logic [63:0] half);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    num = {64'd0, x} * {64'd0, x};
    den = num + {64'd0, half} * {64'd0, half};
    if (den == 0) return 64'd0;
    q = (num << 40) / den;
    return q[63:0];
  endfunction

  function automatic logic [63:0] neg_ln_q40(input logic [31:0] x);
    int e;
    logic [63:0] mant;
    logic [63:0] frac;
    logic [63:0] l;
    e = 0;
    for (int b = 31; b >= 0; b--) begin
      if (x[b] && e == 0 && b > 0) e = b;
    end
    mant = {32'd0, x} << (31 - e);
    frac = 0;
    for (int i = 0; i < 32; i++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        frac[0] = 1'b1;
      end
    end
    l = ({32'd0, 32'(32 - e)} << 32) - frac;
    return mul_shift_clip(l, gg_pkg::LN2_Q40, 32);
  endfunction

  function automatic logic [63:0] bump(input logic [63:0] v, input bit up,
                                       input logic [63:0] top);
    if (up) return (v >= top) ? v : v + 1;
    return (v == 0) ? 64'd0 : v - 1;
  endfunction

  function automatic gg_result_t gillespie_event(input logic [31:0] rt, input logic [31:0] rp);
    logic [63:0] prop [9];
    logic [63:0] cum [9];
    logic [63:0] a0, tau, target, lnv;
    int pick;
    bit taken;
    gg_result_t r;
    taken = 0;
    pick = gg_pkg::LAST_REACTION;
    if (rt != 0 && rp != 0) begin
      prop[0] = add_clip(basal_k, mul_shift_clip(max_k, hill_q40(k_lvl, k_half), 40));
      prop[1] = add_clip(basal_m, mul_shift_clip(max_m, hill_q40(k_lvl, m_half), 40));
      prop[2] = mul_shift_clip(gg_pkg::RATE_TRANSLATE, km_lvl, 0);
      prop[3] = mul_shift_clip(gg_pkg::RATE_TRANSLATE, mm_lvl, 0);
      prop[4] = mul_shift_clip(binding, mul_shift_clip(m_lvl, k_lvl, 0), 0);
      prop[5] = mul_shift_clip(gg_pkg::RATE_MRNA_DECAY, km_lvl, 0);
      prop[6] = mul_shift_clip(gg_pkg::RATE_MRNA_DECAY, mm_lvl, 0);
      prop[7] = mul_shift_clip(gg_pkg::RATE_PROT_DECAY, m_lvl, 0);
      prop[8] = mul_shift_clip(gg_pkg::RATE_PROT_DECAY, k_lvl, 0);
      a0 = 0;
      for (int i = 0; i < 9; i++) begin
        a0 = add_clip(a0, prop[i]);
        cum[i] = a0;
      end
      if (a0 != 0) begin
        taken = 1;
        lnv = neg_ln_q40(rt);
        tau = (lnv << 16) / a0;
        sim_clock = add_clip(sim_clock, tau);
        if (sim_clock > 64'hFFFF_FFFF_FFFF) sim_clock = 64'hFFFF_FFFF_FFFF;
        target = mul_shift_clip(a0, {32'd0, rp}, 32);
        for (int i = 8; i >= 0; i--) begin
          if (target < cum[i]) pick = i;
        end
        case (pick)
          0: km_lvl = bump(km_lvl, 1, 64'hFFFF);
          1: mm_lvl = bump(mm_lvl, 1, 64'hFFFF);
          2: k_lvl = bump(k_lvl, 1, 64'hFFFFF);
          3: m_lvl = bump(m_lvl, 1, 64'hFFFFF);
          5: km_lvl = bump(km_lvl, 0, 64'hFFFF);
          6: mm_lvl = bump(mm_lvl, 0, 64'hFFFF);
          7: m_lvl = bump(m_lvl, 0, 64'hFFFFF);
          default: k_lvl = bump(k_lvl, 0, 64'hFFFFF);
        endcase
      end
    end
    r.step_taken = taken;
    r.reaction = taken ? 4'(pick) : 4'd0;
    r.event_time = sim_clock[47:0];
    r.k_count = k_lvl[19:0];
    r.m_count = m_lvl[19:0];
    r.k_mrna_count = km_lvl[15:0];
    r.m_mrna_count = mm_lvl[15:0];
    return r;
  endfunction

  task automatic write_reg(input gg_pkg::cfg_reg_e idx, input logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      gg_pkg::CFG_BASAL_K: basal_k = {16'd0, val};
      gg_pkg::CFG_MAX_K:   max_k = {16'd0, val};
      gg_pkg::CFG_BASAL_M: basal_m = {16'd0, val};
      gg_pkg::CFG_MAX_M:   max_m = {16'd0, val};
      gg_pkg::CFG_K_HALF:  k_half = {44'd0, val[19:0]};
      gg_pkg::CFG_M_HALF:  m_half = {44'd0, val[19:0]};
      default:             binding = {16'd0, val};
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain_results();
    wait (results_due.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin gap_pct = 0; stall_pct = 0; end
      1: begin gap_pct = 48; stall_pct = 0; end
      2: begin gap_pct = 0; stall_pct = 48; end
      default: begin gap_pct = 25; stall_pct = 25; end
    endcase
  endtask

  // one input transfer; typed rows carry their own expected result
  task automatic send_item(input stim_row_t row);
    gg_result_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.rand_time <= row.rand_time;
    in_ch.rand_pick <= row.rand_pick;
    do @(posedge clk); while (!in_ch.ready);
    predicted = gillespie_event(row.rand_time, row.rand_pick);
    results_due.push_back(row.typed ? row.result : predicted);
  endtask

  task automatic send_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_fraction();
    if ($urandom_range(39) == 0) return 32'd0;
    case ($urandom_range(9))
      0: return 32'd1 + $urandom_range(15);
      1: return 32'hFFFF_FFFF - $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_items(input int n);
    stim_row_t row;
    for (int i = 0; i < n; i++) begin
      row.rand_time = rand_fraction();
      row.rand_pick = rand_fraction();
      row.typed = 0;
      send_item(row);
    end
    send_idle();
  endtask

  function automatic logic [47:0] rand_rate();
    case ($urandom_range(3))
      0: return 48'd0;
      1: return RATE_MAX;
      default: return 48'({$urandom, $urandom} >> $urandom_range(47));
    endcase
  endfunction

  // receiver: random stalls, set on the falling edge
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    gg_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, reaction %0d", $time, out_ch.reaction);
      end else begin
        want = results_due.pop_front();
        if (out_ch.step_taken) begin
          events_seen++;
          if (out_ch.reaction < 9) reactions_hit[out_ch.reaction] = 1'b1;
        end
        if (out_ch.step_taken !== want.step_taken || out_ch.reaction !== want.reaction ||
            out_ch.event_time !== want.event_time || out_ch.k_count !== want.k_count ||
            out_ch.m_count !== want.m_count || out_ch.k_mrna_count !== want.k_mrna_count ||
            out_ch.m_mrna_count !== want.m_mrna_count) begin
          errors++;
          $display("%0t: expected step %0d rx %0d t %h K %0d M %0d km %0d mm %0d", $time,
                   want.step_taken, want.reaction, want.event_time, want.k_count,
                   want.m_count, want.k_mrna_count, want.m_mrna_count);
          $display("%0t: actual   step %0d rx %0d t %h K %0d M %0d km %0d mm %0d", $time,
                   out_ch.step_taken, out_ch.reaction, out_ch.event_time, out_ch.k_count,
                   out_ch.m_count, out_ch.k_mrna_count, out_ch.m_mrna_count);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", results_due.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    gg_result_t at_reset;
    in_ch.valid = 1'b0;
    in_ch.rand_time = '0;
    in_ch.rand_pick = '0;
    basal_k = gg_pkg::BASAL_K_RST; max_k = gg_pkg::MAX_K_RST;
    basal_m = gg_pkg::BASAL_M_RST; max_m = gg_pkg::MAX_M_RST;
    k_half = gg_pkg::K_HALF_RST; m_half = gg_pkg::M_HALF_RST; binding = gg_pkg::BINDING_RST;
    sim_clock = 0; k_lvl = 500; m_lvl = 150; km_lvl = 0; mm_lvl = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero fractions are ignored and echo the reset state; corner-case fractions follow, then random ones
    at_reset = '{0, 4'd0, 48'd0, 20'd500, 20'd150, 16'd0, 16'd0};
    rows.push_back('{32'd0, 32'd0, 1, at_reset});
    rows.push_back('{32'd0, 32'hFFFF_FFFF, 1, at_reset});
    rows.push_back('{32'hFFFF_FFFF, 32'd0, 1, at_reset});
    rows.push_back('{32'd0, 32'd1, 1, at_reset});
    rows.push_back('{32'd1, 32'd1, 0, at_reset});
    rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, at_reset});
    rows.push_back('{32'd1, 32'hFFFF_FFFF, 0, at_reset});
    rows.push_back('{32'hFFFF_FFFF, 32'd1, 0, at_reset});
    rows.push_back('{32'h8000_0000, 32'h8000_0000, 0, at_reset});
    rows.push_back('{32'd2, 32'h7FFF_FFFF, 0, at_reset});
    rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 0, at_reset});
    rows.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 0, at_reset});
    rows.push_back('{32'd0, 32'h1234_5678, 0, at_reset});
    for (int i = 0; i < 8; i++) rows.push_back('{32'd1 << (i * 4), 32'hFFFF_FFFF >> i, 0,
                                                  at_reset});
    foreach (rows[i]) send_item(rows[i]);
    send_idle();
    random_items(350);
    drain_results();

    // extremes: full-scale rates and half levels
    set_idling(1);
    write_reg(gg_pkg::CFG_BASAL_K, RATE_MAX);
    write_reg(gg_pkg::CFG_MAX_K, RATE_MAX);
    write_reg(gg_pkg::CFG_BASAL_M, RATE_MAX);
    write_reg(gg_pkg::CFG_MAX_M, RATE_MAX);
    write_reg(gg_pkg::CFG_K_HALF, {28'd0, HALF_MAX});
    write_reg(gg_pkg::CFG_M_HALF, {28'd0, HALF_MAX});
    write_reg(gg_pkg::CFG_BINDING, RATE_MAX);
    end_writes();
    random_items(200);
    drain_results();

    // zero half levels make the hill terms a step function
    set_idling(2);
    write_reg(gg_pkg::CFG_K_HALF, 48'd0);
    write_reg(gg_pkg::CFG_M_HALF, 48'd0);
    write_reg(gg_pkg::CFG_BASAL_K, rand_rate());
    write_reg(gg_pkg::CFG_MAX_K, rand_rate());
    write_reg(gg_pkg::CFG_BASAL_M, rand_rate());
    write_reg(gg_pkg::CFG_MAX_M, rand_rate());
    write_reg(gg_pkg::CFG_BINDING, rand_rate());
    end_writes();
    random_items(200);
    drain_results();

    set_idling(3);
    write_reg(gg_pkg::CFG_K_HALF, 48'd1);
    write_reg(gg_pkg::CFG_M_HALF, 48'd1 + $urandom_range(20000));
    write_reg(gg_pkg::CFG_BINDING, RATE_MAX);
    end_writes();
    random_items(120);
    drain_results();

    // no production: binding and decay empty the cell, then every input is ignored
    set_idling(0);
    write_reg(gg_pkg::CFG_BASAL_K, 48'd0);
    write_reg(gg_pkg::CFG_MAX_K, 48'd0);
    write_reg(gg_pkg::CFG_BASAL_M, 48'd0);
    write_reg(gg_pkg::CFG_MAX_M, 48'd0);
    write_reg(gg_pkg::CFG_BINDING, 48'h100_0000_0000);
    end_writes();
    random_items(720);
    drain_results();

    set_idling(3);
    write_reg(gg_pkg::CFG_BASAL_K, gg_pkg::BASAL_K_RST);
    write_reg(gg_pkg::CFG_MAX_K, gg_pkg::MAX_K_RST);
    write_reg(gg_pkg::CFG_BASAL_M, gg_pkg::BASAL_M_RST);
    write_reg(gg_pkg::CFG_MAX_M, gg_pkg::MAX_M_RST);
    write_reg(gg_pkg::CFG_K_HALF, {28'd0, gg_pkg::K_HALF_RST});
    write_reg(gg_pkg::CFG_M_HALF, {28'd0, gg_pkg::M_HALF_RST});
    write_reg(gg_pkg::CFG_BINDING, gg_pkg::BINDING_RST);
    end_writes();
    random_items(150);
    drain_results();
    repeat (500) @(posedge clk);

    $display("checked %0d results, %0d of them events, the rest ignored inputs",
             results_seen, events_seen);
    $display("reactions fired (bit per reaction 8..0): %b", reactions_hit);
    if (errors == 0 && results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, results_due.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
design/gg_pkg.sv
design/gg_if.sv
design/gg_mul.sv
design/gg_div.sv
design/gillespie_gene_circuit_step.sv
design/gg_chk.sv
sim/gillespie_gene_circuit_step_tb.sv
